// File: hdl/qpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared widths, codes and helper functions for the quaternion product unit.
// ----------------------------------------------------------------------------
package qpr_pkg;

  localparam int CW        = 32;            // component width
  localparam int FRAC      = CW - 2;        // fraction bits
  localparam int PW        = 2 * CW;        // magnitude product width
  localparam int AW        = PW + 2;        // signed accumulator / square sum
  localparam int RW        = CW + 1;        // root width
  localparam int NW        = CW + FRAC;     // dividend / quotient width
  localparam int MUL_CNT_W = $clog2(CW);
  localparam int SQ_STEPS  = AW / 2;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);
  localparam int DIV_CNT_W = $clog2(NW);

  localparam logic [7:0]  PERIOD_RESET = 8'd100;
  localparam logic [2:0]  ADDR_W       = 3'd0;
  localparam logic        REG_RENORM_PERIOD = 1'b0;   // register index, paddr[2]

  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  localparam logic signed [CW-1:0] COMP_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [NW-1:0]        QUO_NEG_LIM = NW'(1) << (CW - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD_GO, ST_PROD_WAIT, ST_DECIDE, ST_SQ_GO, ST_SQ_WAIT,
    ST_ROOT_GO, ST_ROOT_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
  } qpr_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } qpr_unit_stat_t;

  // operand selection of the Hamilton product: {negate, a index}
  function automatic logic [2:0] term_sel(input logic [1:0] comp, input logic [1:0] term);
    logic [2:0] s;
    case ({comp, term})
      {IDX_X, 2'd0}: s = {1'b0, IDX_X};
      {IDX_X, 2'd1}: s = {1'b0, IDX_W};
      {IDX_X, 2'd2}: s = {1'b0, IDX_Z};
      {IDX_X, 2'd3}: s = {1'b1, IDX_Y};
      {IDX_Y, 2'd0}: s = {1'b0, IDX_Y};
      {IDX_Y, 2'd1}: s = {1'b1, IDX_Z};
      {IDX_Y, 2'd2}: s = {1'b0, IDX_W};
      {IDX_Y, 2'd3}: s = {1'b0, IDX_X};
      {IDX_Z, 2'd0}: s = {1'b0, IDX_Z};
      {IDX_Z, 2'd1}: s = {1'b0, IDX_Y};
      {IDX_Z, 2'd2}: s = {1'b1, IDX_X};
      {IDX_Z, 2'd3}: s = {1'b0, IDX_W};
      {IDX_W, 2'd0}: s = {1'b0, IDX_W};
      {IDX_W, 2'd1}: s = {1'b1, IDX_X};
      {IDX_W, 2'd2}: s = {1'b1, IDX_Y};
      {IDX_W, 2'd3}: s = {1'b1, IDX_Z};
      default:       s = {1'b0, IDX_X};
    endcase
    return s;
  endfunction

  // left operand walks w, x, y, z
  function automatic logic [1:0] b_sel(input logic [1:0] term);
    logic [1:0] s;
    case (term)
      2'd0:    s = IDX_W;
      2'd1:    s = IDX_X;
      2'd2:    s = IDX_Y;
      2'd3:    s = IDX_Z;
      default: s = IDX_W;
    endcase
    return s;
  endfunction

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // arithmetic shift by FRAC, then clamp to the component range
  function automatic logic signed [CW-1:0] sat_acc(input logic signed [AW-1:0] acc);
    logic [AW-FRAC-1:0] sh;
    logic [AW-FRAC-CW:0] up;
    sh = acc[AW-1:FRAC];
    up = sh[AW-FRAC-1:CW-1];
    if (&up || ~|up) return sh[CW-1:0];
    return sh[AW-FRAC-1] ? COMP_MIN : COMP_MAX;
  endfunction

  function automatic logic signed [CW-1:0] sat_quo(input logic [NW-1:0] q, input logic neg);
    if (!neg) return (|q[NW-1:CW-1]) ? COMP_MAX : q[CW-1:0];
    if (q > QUO_NEG_LIM) return COMP_MIN;
    return CW'(-q[CW-1:0]);
  endfunction

endpackage

// File: hdl/qpr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_in_if / qpr_out_if
// Valid/ready channels for operand pairs and product results.
// ----------------------------------------------------------------------------
interface qpr_in_if import qpr_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] a_x, a_y, a_z, a_w;
  logic signed [CW-1:0] b_x, b_y, b_z, b_w;
  modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
  modport sink   (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
endinterface

interface qpr_out_if import qpr_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] r_x, r_y, r_z, r_w;
  logic renormalized;
  logic zero_norm;
  modport source (output valid, r_x, r_y, r_z, r_w, renormalized, zero_norm, input ready);
  modport sink   (input valid, r_x, r_y, r_z, r_w, renormalized, zero_norm, output ready);
endinterface

// File: hdl/qpr_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module qpr_serial_mul import qpr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CW-1:0]    mcand,
  input  logic [CW-1:0]    mplier,
  output logic [PW-1:0]    product,
  output qpr_unit_stat_t   stat
);

  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]        mcand_r, mcand_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  logic [CW:0]          sum;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    sum       = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = MUL_CNT_W'(CW - 1);
      mcand_nxt = mcand;
      hi_nxt    = '0;
      lo_nxt    = mplier;
    end else if (busy_r) begin
      // add, then shift the partial product right by one
      hi_nxt = sum[CW:1];
      lo_nxt = {sum[0], lo_r[CW-1:1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign product   = {hi_r, lo_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hdl/qpr_serial_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_serial_sqrt
// Integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module qpr_serial_sqrt import qpr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [AW-1:0]   radicand,
  output logic [RW-1:0]   root,
  output qpr_unit_stat_t  stat
);

  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]       s_r, s_nxt;
  logic [RW:0]         rem_r, rem_nxt;
  logic [RW-1:0]       root_r, root_nxt;
  logic [RW+2:0]       rem_sh, trial, diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    s_nxt    = s_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r, s_r[AW-1:AW-2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_sh - trial;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SQ_CNT_W'(SQ_STEPS - 1);
      s_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      s_nxt = {s_r[AW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = diff[RW:0];
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[RW:0];
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hdl/qpr_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_serial_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpr_serial_div import qpr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NW-1:0]   dividend,
  input  logic [RW-1:0]   divisor,
  output logic [NW-1:0]   quotient,
  output qpr_unit_stat_t  stat
);

  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]        num_r, num_nxt;
  logic [RW-1:0]        rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [RW:0]          rem_sh, diff;
  logic                 ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r, num_r[NW-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    ge       = rem_sh >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(NW - 1);
      num_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      num_nxt = {num_r[NW-2:0], ge};
      rem_nxt = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient  = num_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hdl/quaternion_product_renormalize_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_product_renormalize_unit
// Hamilton product b*a of Q1.30 quaternions with periodic unit-length rescale.
// ----------------------------------------------------------------------------
// One item at a time. Each of the sixteen partial products runs through a
// single bit-serial multiplier. When the product counter passes
// renorm_period, four squares go through the same multiplier, the magnitude
// comes from a bit-serial square root and, unless that magnitude is zero,
// each component is scaled by a restoring divider that yields one quotient
// bit per cycle. A new item is taken once the previous result sits in the
// output register; the output register holds it until the sink takes the
// transfer. Register renorm_period lives at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module quaternion_product_renormalize_unit import qpr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  qpr_in_if.sink        in_chan,
  qpr_out_if.source     out_chan,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  qpr_state_t state_r, state_nxt;

  logic signed [CW-1:0] a_r [4];
  logic signed [CW-1:0] b_r [4];
  logic signed [CW-1:0] res_r [4];
  logic signed [CW-1:0] res_nxt [4];
  logic [1:0]           comp_r, comp_nxt, term_r, term_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt, acc_sum;
  logic [AW-1:0]        sum_r, sum_nxt;
  logic [RW-1:0]        root_r, root_nxt;
  logic [7:0]           cnt_r, cnt_nxt, period_r;
  logic [8:0]           cnt_inc;
  logic                 ren_r, ren_nxt, zero_r, zero_nxt;
  logic                 in_acc, out_load, cfg_wr;

  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r, out_w_r;
  logic                 out_valid_r, out_ren_r, out_zero_r;

  logic [2:0]           sel;
  logic [1:0]           b_idx;
  logic signed [CW-1:0] op_a, op_b;
  logic                 prod_neg;

  logic                 mul_start, sqrt_start, div_start;
  logic [CW-1:0]        mul_x, mul_y;
  logic [PW-1:0]        mul_p;
  logic [RW-1:0]        sqrt_root;
  logic [NW-1:0]        div_q;
  qpr_unit_stat_t       mul_st, sqrt_st, div_st;

  // --------------------------------------------------------------------------
  // Configuration: one writable register, always ready
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_RENORM_PERIOD) ? {24'd0, period_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr && paddr[2] == REG_RENORM_PERIOD) begin
      period_r <= pwdata[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Operand selection for the shared multiplier
  // --------------------------------------------------------------------------
  assign sel      = term_sel(comp_r, term_r);
  assign b_idx    = b_sel(term_r);
  assign op_a     = a_r[sel[1:0]];
  assign op_b     = b_r[b_idx];
  assign prod_neg = sel[2] ^ op_a[CW-1] ^ op_b[CW-1];

  assign mul_x = (state_r == ST_SQ_GO) ? mag(res_r[comp_r]) : mag(op_a);
  assign mul_y = (state_r == ST_SQ_GO) ? mag(res_r[comp_r]) : mag(op_b);

  assign acc_sum = prod_neg ? acc_r - $signed({2'b00, mul_p})
                            : acc_r + $signed({2'b00, mul_p});
  assign cnt_inc = {1'b0, cnt_r} + 9'd1;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    comp_nxt   = comp_r;
    term_nxt   = term_r;
    acc_nxt    = acc_r;
    sum_nxt    = sum_r;
    root_nxt   = root_r;
    cnt_nxt    = cnt_r;
    ren_nxt    = ren_r;
    zero_nxt   = zero_r;
    res_nxt    = res_r;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          comp_nxt  = IDX_X;
          term_nxt  = 2'd0;
          acc_nxt   = '0;
          ren_nxt   = 1'b0;
          zero_nxt  = 1'b0;
          state_nxt = ST_PROD_GO;
        end
      end
      ST_PROD_GO: begin
        mul_start = 1'b1;
        state_nxt = ST_PROD_WAIT;
      end
      ST_PROD_WAIT: begin
        if (mul_st.done) begin
          if (term_r == 2'd3) begin
            // close out this component
            res_nxt[comp_r] = sat_acc(acc_sum);
            acc_nxt  = '0;
            term_nxt = 2'd0;
            if (comp_r == IDX_W) begin
              state_nxt = ST_DECIDE;
            end else begin
              comp_nxt  = comp_r + 2'd1;
              state_nxt = ST_PROD_GO;
            end
          end else begin
            acc_nxt   = acc_sum;
            term_nxt  = term_r + 2'd1;
            state_nxt = ST_PROD_GO;
          end
        end
      end
      ST_DECIDE: begin
        if (cnt_inc > {1'b0, period_r}) begin
          cnt_nxt   = '0;
          comp_nxt  = IDX_X;
          sum_nxt   = '0;
          state_nxt = ST_SQ_GO;
        end else begin
          cnt_nxt   = cnt_inc[7:0];
          state_nxt = ST_DONE;
        end
      end
      ST_SQ_GO: begin
        mul_start = 1'b1;
        state_nxt = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_st.done) begin
          sum_nxt = sum_r + {2'b00, mul_p};
          if (comp_r == IDX_W) begin
            if (sum_nxt == '0) begin
              // zero magnitude: skip the rescale
              zero_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_ROOT_GO;
            end
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = ST_SQ_GO;
          end
        end
      end
      ST_ROOT_GO: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sqrt_st.done) begin
          root_nxt  = sqrt_root;
          comp_nxt  = IDX_X;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_st.done) begin
          res_nxt[comp_r] = sat_quo(div_q, res_r[comp_r][CW-1]);
          if (comp_r == IDX_W) begin
            ren_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      comp_r      <= IDX_X;
      term_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
      term_r  <= term_nxt;
      if (out_load)            out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // hold operands and working values; no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r[IDX_X] <= in_chan.a_x;
      a_r[IDX_Y] <= in_chan.a_y;
      a_r[IDX_Z] <= in_chan.a_z;
      a_r[IDX_W] <= in_chan.a_w;
      b_r[IDX_X] <= in_chan.b_x;
      b_r[IDX_Y] <= in_chan.b_y;
      b_r[IDX_Z] <= in_chan.b_z;
      b_r[IDX_W] <= in_chan.b_w;
    end
    res_r  <= res_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    root_r <= root_nxt;
    ren_r  <= ren_nxt;
    zero_r <= zero_nxt;
    if (out_load) begin
      out_x_r    <= res_r[IDX_X];
      out_y_r    <= res_r[IDX_Y];
      out_z_r    <= res_r[IDX_Z];
      out_w_r    <= res_r[IDX_W];
      out_ren_r  <= ren_r;
      out_zero_r <= zero_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.r_x          = out_x_r;
  assign out_chan.r_y          = out_y_r;
  assign out_chan.r_z          = out_z_r;
  assign out_chan.r_w          = out_w_r;
  assign out_chan.renormalized = out_ren_r;
  assign out_chan.zero_norm    = out_zero_r;

  // --------------------------------------------------------------------------
  // Serial arithmetic units
  // --------------------------------------------------------------------------
  qpr_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_x),
    .mplier  (mul_y),
    .product (mul_p),
    .stat    (mul_st)
  );

  qpr_serial_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .root     (sqrt_root),
    .stat     (sqrt_st)
  );

  qpr_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mag(res_r[comp_r]), {FRAC{1'b0}}}),
    .divisor  (root_r),
    .quotient (div_q),
    .stat     (div_st)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_st.busy)
    else $error("multiplier restarted while busy");

  a_units_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !mul_st.busy && !sqrt_st.busy && !div_st.busy)
    else $error("item taken while an arithmetic unit still runs");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(ren_r && zero_r))
    else $error("renormalized and zero_norm both set");

  a_counter_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (ren_r || zero_r)) |-> cnt_r == 8'd0)
    else $error("counter not cleared on a rescale");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> root_r != '0)
    else $error("divide started with zero magnitude");

endmodule
